[rtl/lpfd_pkg.sv]
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types and constants
// Types, register indexes and codes for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int FRONT_BYTES  = 8;
  localparam int RAW_BYTES    = 4;
  localparam int SIZE_W       = 27;

  localparam logic [SIZE_W-1:0] MAX_FRAME_RST = SIZE_W'(64 * 1024 * 1024);
  localparam logic [7:0]        COMP_MASK_RST = 8'h01;
  localparam logic [7:0]        DICT_MASK_RST = 8'h02;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OVERSIZE = 2'd0,
    ERR_SHORT    = 2'd1,
    ERR_RAW_SIZE = 2'd2,
    ERR_NO_DICT  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    REG_MAX_FRAME    = 2'd0,
    REG_COMP_MASK    = 2'd1,
    REG_DICT_MASK    = 2'd2,
    REG_DICT_PRESENT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] max_frame_size;
    logic [7:0]        compressed_mask;
    logic [7:0]        dictionary_mask;
    logic              dictionary_present;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        msg_type;
    logic [7:0]        msg_flags;
    logic [7:0]        msg_domain;
    logic [7:0]        msg_code;
    logic [31:0]       serial_number;
    logic [SIZE_W-1:0] frame_size;
    logic [7:0]        data_byte;
    logic              last_of_frame;
    err_t              error_code;
  } item_t;

endpackage

[rtl/lpfd_cfg.sv]
// ----------------------------------------------------------------------------
// lpfd_cfg: configuration registers
// Holds the size limit, flag masks and dictionary status; always ready.
// ----------------------------------------------------------------------------
module lpfd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [lpfd_pkg::SIZE_W-1:0]  cfg_data,
  output lpfd_pkg::cfg_t               cfg_o
);

  lpfd_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_size     <= lpfd_pkg::MAX_FRAME_RST;
      cfg_r.compressed_mask    <= lpfd_pkg::COMP_MASK_RST;
      cfg_r.dictionary_mask    <= lpfd_pkg::DICT_MASK_RST;
      cfg_r.dictionary_present <= 1'b0;
    end else if (cfg_valid) begin
      unique case (lpfd_pkg::reg_idx_t'(cfg_index))
        lpfd_pkg::REG_MAX_FRAME:    cfg_r.max_frame_size     <= cfg_data;
        lpfd_pkg::REG_COMP_MASK:    cfg_r.compressed_mask    <= cfg_data[7:0];
        lpfd_pkg::REG_DICT_MASK:    cfg_r.dictionary_mask    <= cfg_data[7:0];
        lpfd_pkg::REG_DICT_PRESENT: cfg_r.dictionary_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/lpfd_parse.sv]
// ----------------------------------------------------------------------------
// lpfd_parse: header and payload parser
// Tracks frame state one byte per step and forms the result of that byte.
// ----------------------------------------------------------------------------
module lpfd_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  input  lpfd_pkg::cfg_t       cfg_i,
  output logic                 res_valid_o,
  output lpfd_pkg::item_t      res_o
);

  localparam int SW = lpfd_pkg::SIZE_W;

  lpfd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]    count_r, count_nxt;
  logic [63:0]   front_r, front_nxt;
  logic [23:0]   size_r, size_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [23:0]   raw_r, raw_nxt;

  logic [31:0] size_full;
  logic [31:0] raw_full;
  logic [7:0]  flags;
  logic        compressed;
  logic        front_load;
  logic        hdr_done;
  logic        oversize;
  logic        too_short;
  logic        raw_active;
  logic        raw_done;
  logic        raw_big;
  logic        dict_miss;
  logic        rem_last;
  logic        raw_fail;

  assign size_full  = {size_r, byte_i};
  assign raw_full   = {raw_r, byte_i};
  assign flags      = front_r[55:48];
  assign compressed = |(flags & cfg_i.compressed_mask);
  assign front_load = count_r < 4'(lpfd_pkg::FRONT_BYTES);
  assign hdr_done   = count_r == 4'(lpfd_pkg::HEADER_BYTES - 1);
  assign oversize   = size_full > {{(32-SW){1'b0}}, cfg_i.max_frame_size};
  assign too_short  = compressed && (size_full < 32'(lpfd_pkg::RAW_BYTES));
  assign raw_active = compressed && (idx_r < 3'(lpfd_pkg::RAW_BYTES));
  assign raw_done   = raw_active && (idx_r == 3'(lpfd_pkg::RAW_BYTES - 1));
  assign raw_big    = raw_full > {{(32-SW){1'b0}}, cfg_i.max_frame_size};
  assign dict_miss  = (raw_full != 32'd0) && (|(flags & cfg_i.dictionary_mask)) &&
                      !cfg_i.dictionary_present;
  assign raw_fail   = raw_done && (raw_big || dict_miss);
  assign rem_last   = rem_r <= SW'(1);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    front_nxt = front_r;
    size_nxt  = size_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    raw_nxt   = raw_r;
    if (step_i) begin
      unique case (phase_r)
        lpfd_pkg::PH_HEADER: begin
          if (front_load) begin
            front_nxt = {front_r[55:0], byte_i};
          end else begin
            size_nxt = size_full[23:0];
          end
          if (hdr_done) begin
            count_nxt = '0;
            if (oversize || too_short) begin
              phase_nxt = lpfd_pkg::PH_ERROR;
            end else if (size_full != 32'd0) begin
              phase_nxt = lpfd_pkg::PH_PAYLOAD;
              rem_nxt   = size_full[SW-1:0];
              idx_nxt   = '0;
            end
          end else begin
            count_nxt = count_r + 4'd1;
          end
        end
        lpfd_pkg::PH_PAYLOAD: begin
          if (raw_active) begin
            raw_nxt = raw_full[23:0];
            idx_nxt = idx_r + 3'd1;
          end
          if (raw_fail) begin
            phase_nxt = lpfd_pkg::PH_ERROR;
          end else if (rem_last) begin
            rem_nxt   = '0;
            phase_nxt = lpfd_pkg::PH_HEADER;
          end else begin
            rem_nxt = rem_r - SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // result of the current byte
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (phase_r)
      lpfd_pkg::PH_HEADER: begin
        res_valid_o = hdr_done;
        if (oversize) begin
          res_o.kind       = lpfd_pkg::KIND_ERROR;
          res_o.error_code = lpfd_pkg::ERR_OVERSIZE;
        end else if (too_short) begin
          res_o.kind       = lpfd_pkg::KIND_ERROR;
          res_o.error_code = lpfd_pkg::ERR_SHORT;
        end else begin
          res_o.kind          = lpfd_pkg::KIND_HEADER;
          res_o.msg_type      = front_r[63:56];
          res_o.msg_flags     = front_r[55:48];
          res_o.msg_domain    = front_r[47:40];
          res_o.msg_code      = front_r[39:32];
          res_o.serial_number = front_r[31:0];
          res_o.frame_size    = size_full[SW-1:0];
          res_o.last_of_frame = size_full == 32'd0;
        end
      end
      lpfd_pkg::PH_PAYLOAD: begin
        res_valid_o = 1'b1;
        if (raw_fail) begin
          res_o.kind       = lpfd_pkg::KIND_ERROR;
          res_o.error_code = raw_big ? lpfd_pkg::ERR_RAW_SIZE : lpfd_pkg::ERR_NO_DICT;
        end else begin
          res_o.kind          = lpfd_pkg::KIND_DATA;
          res_o.data_byte     = byte_i;
          res_o.last_of_frame = rem_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lpfd_pkg::PH_HEADER;
      count_r <= '0;
      rem_r   <= '0;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    size_r  <= size_nxt;
    raw_r   <= raw_nxt;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < 4'(lpfd_pkg::HEADER_BYTES))
    else $error("header count out of range");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lpfd_pkg::PH_PAYLOAD |-> rem_r != '0)
    else $error("payload phase with nothing remaining");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lpfd_pkg::PH_ERROR |=> phase_r == lpfd_pkg::PH_ERROR)
    else $error("left error phase without reset");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 3'(lpfd_pkg::RAW_BYTES))
    else $error("raw size index out of range");

  a_no_result_in_error: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == lpfd_pkg::PH_ERROR |-> !res_valid_o)
    else $error("result produced after error");
`endif

endmodule

[rtl/length_prefixed_frame_deframer.sv]
// A byte accepted at in_* passes the input register, then the result register,
// before its result appears at out_*. Throughput: one byte per cycle unless a
// result is stalled at out_*; a stalled result holds only the input stage.
// Bytes that complete no item (header bytes, bytes after an error) give no result.
// Reset (rst_n low, synchronous) restores default registers and the header phase,
// and clears any error.
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer: byte stream to header and payload items
// Parses 12-byte big-endian headers, forwards payload bytes, flags errors.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_item_kind,
  output logic [7:0]                  out_msg_type,
  output logic [7:0]                  out_msg_flags,
  output logic [7:0]                  out_msg_domain,
  output logic [7:0]                  out_msg_code,
  output logic [31:0]                 out_serial_number,
  output logic [lpfd_pkg::SIZE_W-1:0] out_frame_size,
  output logic [7:0]                  out_data_byte,
  output logic                        out_last_of_frame,
  output logic [1:0]                  out_error_code,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [lpfd_pkg::SIZE_W-1:0] cfg_data
);

  lpfd_pkg::cfg_t  cfg;
  lpfd_pkg::item_t res;
  lpfd_pkg::item_t out_item_r;
  logic            res_valid;
  logic            s1_valid_r;
  logic [7:0]      s1_byte_r;
  logic            out_valid_r;
  logic            step;

  assign step     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !step;

  lpfd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  lpfd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .byte_i      (s1_byte_r),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = out_item_r.kind;
  assign out_msg_type      = out_item_r.msg_type;
  assign out_msg_flags     = out_item_r.msg_flags;
  assign out_msg_domain    = out_item_r.msg_domain;
  assign out_msg_code      = out_item_r.msg_code;
  assign out_serial_number = out_item_r.serial_number;
  assign out_frame_size    = out_item_r.frame_size;
  assign out_data_byte     = out_item_r.data_byte;
  assign out_last_of_frame = out_item_r.last_of_frame;
  assign out_error_code    = out_item_r.error_code;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: length_prefixed_frame_deframer
// Sends well-formed frames with random content and random register settings,
// predicts the header, payload and error items, and compares them with the
// block's results.
// Each run ends with one error frame of a randomly chosen kind, since an error
// leaves the block silent until reset.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  class deframe_checker;
    logic [lpfd_pkg::SIZE_W-1:0] max_frame;
    logic [7:0]                  comp_mask;
    logic [7:0]                  dict_mask;
    logic                        dict_present;

    lpfd_pkg::phase_t            phase;
    logic [3:0]                  hdr_count;
    logic [63:0]                 front;
    logic [31:0]                 size_acc;
    logic [lpfd_pkg::SIZE_W-1:0] remaining;
    logic [2:0]                  raw_count;
    logic [31:0]                 raw_acc;

    lpfd_pkg::item_t             expected_items[$];
    int                          errors;

    function new();
      max_frame    = lpfd_pkg::MAX_FRAME_RST;
      comp_mask    = lpfd_pkg::COMP_MASK_RST;
      dict_mask    = lpfd_pkg::DICT_MASK_RST;
      dict_present = 1'b0;
      phase        = lpfd_pkg::PH_HEADER;
      hdr_count    = '0;
      front        = '0;
      size_acc     = '0;
      remaining    = '0;
      raw_count    = '0;
      raw_acc      = '0;
      errors       = 0;
    endfunction

    function void write_reg(lpfd_pkg::reg_idx_t idx, logic [lpfd_pkg::SIZE_W-1:0] v);
      case (idx)
        lpfd_pkg::REG_MAX_FRAME:    max_frame    = v;
        lpfd_pkg::REG_COMP_MASK:    comp_mask    = v[7:0];
        lpfd_pkg::REG_DICT_MASK:    dict_mask    = v[7:0];
        lpfd_pkg::REG_DICT_PRESENT: dict_present = v[0];
        default: ;
      endcase
    endfunction

    function void fail_item(lpfd_pkg::err_t code);
      lpfd_pkg::item_t it;
      it            = '0;
      it.kind       = lpfd_pkg::KIND_ERROR;
      it.error_code = code;
      expected_items.push_back(it);
      phase = lpfd_pkg::PH_ERROR;
    endfunction

    function void take_byte(logic [7:0] b);
      lpfd_pkg::item_t it;
      logic [7:0]      flags;
      it    = '0;
      flags = front[55:48];
      case (phase)
        lpfd_pkg::PH_HEADER: begin
          if (hdr_count < lpfd_pkg::FRONT_BYTES) front = {front[55:0], b};
          else size_acc = {size_acc[23:0], b};
          hdr_count = hdr_count + 4'd1;
          if (hdr_count == lpfd_pkg::HEADER_BYTES) begin
            hdr_count = '0;
            flags = front[55:48];
            if (size_acc > {5'd0, max_frame}) begin
              fail_item(lpfd_pkg::ERR_OVERSIZE);
            end else if ((flags & comp_mask) != 0 && size_acc < lpfd_pkg::RAW_BYTES) begin
              fail_item(lpfd_pkg::ERR_SHORT);
            end else begin
              it.kind          = lpfd_pkg::KIND_HEADER;
              it.msg_type      = front[63:56];
              it.msg_flags     = front[55:48];
              it.msg_domain    = front[47:40];
              it.msg_code      = front[39:32];
              it.serial_number = front[31:0];
              it.frame_size    = size_acc[lpfd_pkg::SIZE_W-1:0];
              it.last_of_frame = (size_acc == 0);
              expected_items.push_back(it);
              if (size_acc != 0) begin
                phase     = lpfd_pkg::PH_PAYLOAD;
                remaining = size_acc[lpfd_pkg::SIZE_W-1:0];
                raw_count = '0;
                raw_acc   = '0;
              end
            end
          end
        end
        lpfd_pkg::PH_PAYLOAD: begin
          if ((flags & comp_mask) != 0 && raw_count < lpfd_pkg::RAW_BYTES) begin
            raw_acc   = {raw_acc[23:0], b};
            raw_count = raw_count + 3'd1;
            if (raw_count == lpfd_pkg::RAW_BYTES) begin
              if (raw_acc > {5'd0, max_frame}) begin
                fail_item(lpfd_pkg::ERR_RAW_SIZE);
                return;
              end
              if (raw_acc != 0 && (flags & dict_mask) != 0 && !dict_present) begin
                fail_item(lpfd_pkg::ERR_NO_DICT);
                return;
              end
            end
          end
          it.kind          = lpfd_pkg::KIND_DATA;
          it.data_byte     = b;
          it.last_of_frame = (remaining <= 1);
          expected_items.push_back(it);
          if (remaining <= 1) begin
            remaining = '0;
            phase     = lpfd_pkg::PH_HEADER;
          end else begin
            remaining = remaining - 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_item(lpfd_pkg::item_t got);
      lpfd_pkg::item_t want;
      if (expected_items.size() == 0) begin
        $display("%0t: result kind %0h with no request pending", $time, got.kind);
        errors++;
        return;
      end
      want = expected_items.pop_front();
      cmp("item_kind", 32'(want.kind), 32'(got.kind));
      cmp("msg_type", 32'(want.msg_type), 32'(got.msg_type));
      cmp("msg_flags", 32'(want.msg_flags), 32'(got.msg_flags));
      cmp("msg_domain", 32'(want.msg_domain), 32'(got.msg_domain));
      cmp("msg_code", 32'(want.msg_code), 32'(got.msg_code));
      cmp("serial_number", want.serial_number, got.serial_number);
      cmp("frame_size", 32'(want.frame_size), 32'(got.frame_size));
      cmp("data_byte", 32'(want.data_byte), 32'(got.data_byte));
      cmp("last_of_frame", 32'(want.last_of_frame), 32'(got.last_of_frame));
      cmp("error_code", 32'(want.error_code), 32'(got.error_code));
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [7:0]                  in_byte;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [1:0]                  out_item_kind;
  logic [7:0]                  out_msg_type;
  logic [7:0]                  out_msg_flags;
  logic [7:0]                  out_msg_domain;
  logic [7:0]                  out_msg_code;
  logic [31:0]                 out_serial_number;
  logic [lpfd_pkg::SIZE_W-1:0] out_frame_size;
  logic [7:0]                  out_data_byte;
  logic                        out_last_of_frame;
  logic [1:0]                  out_error_code;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [1:0]                  cfg_index;
  logic [lpfd_pkg::SIZE_W-1:0] cfg_data;

  deframe_checker sb = new();
  int send_idle  = 0;
  int recv_idle  = 0;
  int bytes_sent = 0;

  length_prefixed_frame_deframer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item_kind    (out_item_kind),
    .out_msg_type     (out_msg_type),
    .out_msg_flags    (out_msg_flags),
    .out_msg_domain   (out_msg_domain),
    .out_msg_code     (out_msg_code),
    .out_serial_number(out_serial_number),
    .out_frame_size   (out_frame_size),
    .out_data_byte    (out_data_byte),
    .out_last_of_frame(out_last_of_frame),
    .out_error_code   (out_error_code),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin : collect
    lpfd_pkg::item_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind          = lpfd_pkg::kind_t'(out_item_kind);
      got.msg_type      = out_msg_type;
      got.msg_flags     = out_msg_flags;
      got.msg_domain    = out_msg_domain;
      got.msg_code      = out_msg_code;
      got.serial_number = out_serial_number;
      got.frame_size    = out_frame_size;
      got.data_byte     = out_data_byte;
      got.last_of_frame = out_last_of_frame;
      got.error_code    = lpfd_pkg::err_t'(out_error_code);
      sb.match_item(got);
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte  = b;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input lpfd_pkg::reg_idx_t idx,
                           input logic [lpfd_pkg::SIZE_W-1:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // header bytes produce no result, so let the pipeline drain past the last one
  task automatic wait_idle(input int settle);
    in_valid = 1'b0;
    while (sb.expected_items.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] t, input logic [7:0] fl,
                            input logic [7:0] dom, input logic [7:0] cd,
                            input logic [31:0] serial, input logic [31:0] size,
                            input logic [31:0] raw, input int body);
    logic [95:0] hdr;
    logic        comp;
    int          i;
    hdr  = {t, fl, dom, cd, serial, size};
    comp = (fl & sb.comp_mask) != 0;
    for (i = 0; i < lpfd_pkg::HEADER_BYTES; i++) send_byte(hdr[95-8*i -: 8]);
    for (i = 0; i < body; i++) begin
      if (comp && i < lpfd_pkg::RAW_BYTES) send_byte(raw[31-8*i -: 8]);
      else send_byte(8'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'(1 << $urandom_range(7));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_setup();
    logic [lpfd_pkg::SIZE_W-1:0] m;
    case ($urandom_range(5))
      0:       m = '0;
      1:       m = lpfd_pkg::MAX_FRAME_RST;
      2:       m = lpfd_pkg::SIZE_W'($urandom_range(16, 1));
      3:       m = lpfd_pkg::SIZE_W'($urandom_range(400, 17));
      4:       m = lpfd_pkg::SIZE_W'($urandom_range(64 * 1024 * 1024, 0));
      default: m = lpfd_pkg::SIZE_W'($urandom_range(64, 4));
    endcase
    write_reg(lpfd_pkg::REG_MAX_FRAME, m);
    write_reg(lpfd_pkg::REG_COMP_MASK, lpfd_pkg::SIZE_W'(pick_mask()));
    write_reg(lpfd_pkg::REG_DICT_MASK, lpfd_pkg::SIZE_W'(pick_mask()));
    write_reg(lpfd_pkg::REG_DICT_PRESENT, lpfd_pkg::SIZE_W'($urandom_range(1)));
  endtask

  task automatic random_frame();
    logic [7:0]  flags;
    logic [31:0] size;
    logic [31:0] raw;
    logic [31:0] lim;
    int          pick;
    lim   = {5'd0, sb.max_frame};
    flags = 8'($urandom);
    pick  = $urandom_range(99);
    if (pick < 70) size = $urandom_range(16, 0);
    else if (pick < 95) size = $urandom_range(64, 17);
    else size = $urandom_range(300, 65);
    if (lim <= 300 && $urandom_range(9) == 0) size = lim;
    if (size > lim) size = lim;
    raw = '0;
    if ((flags & sb.comp_mask) != 0) begin
      if (lim < lpfd_pkg::RAW_BYTES) flags = flags & ~sb.comp_mask;
      else if (size < lpfd_pkg::RAW_BYTES)
        size = $urandom_range(lim < 12 ? lim : 12, lpfd_pkg::RAW_BYTES);
    end
    if ((flags & sb.comp_mask) != 0) begin
      case ($urandom_range(3))
        0:       raw = '0;
        1:       raw = lim;
        default: raw = $urandom % (lim + 1);
      endcase
      if (raw != 0 && (flags & sb.dict_mask) != 0 && !sb.dict_present) raw = '0;
    end
    send_frame(8'($urandom), flags, 8'($urandom), 8'($urandom), $urandom, size, raw,
               int'(size));
  endtask

  task automatic error_frame();
    logic [7:0]  flags;
    logic [31:0] size;
    logic [31:0] raw;
    logic [31:0] lim;
    int          body;
    write_reg(lpfd_pkg::REG_MAX_FRAME, lpfd_pkg::SIZE_W'($urandom_range(4096, 16)));
    write_reg(lpfd_pkg::REG_COMP_MASK, lpfd_pkg::SIZE_W'(8'(1 << $urandom_range(7))));
    write_reg(lpfd_pkg::REG_DICT_MASK, lpfd_pkg::SIZE_W'(8'(1 << $urandom_range(7))));
    write_reg(lpfd_pkg::REG_DICT_PRESENT, '0);
    lim   = {5'd0, sb.max_frame};
    flags = 8'($urandom);
    raw   = '0;
    body  = lpfd_pkg::RAW_BYTES;
    case (lpfd_pkg::err_t'($urandom_range(3)))
      lpfd_pkg::ERR_OVERSIZE: begin
        size = $urandom_range(1) ? lim + 1 : 32'hFFFF_FFFF - $urandom_range(255);
      end
      lpfd_pkg::ERR_SHORT: begin
        flags = flags | sb.comp_mask;
        size  = $urandom_range(lpfd_pkg::RAW_BYTES - 1, 0);
      end
      lpfd_pkg::ERR_RAW_SIZE: begin
        flags = flags | sb.comp_mask;
        size  = $urandom_range(20, lpfd_pkg::RAW_BYTES);
        raw   = $urandom_range(1) ? lim + 1 : 32'hFFFF_FFFF;
        body  = int'(size);
      end
      default: begin
        flags = flags | sb.comp_mask | sb.dict_mask;
        size  = $urandom_range(20, lpfd_pkg::RAW_BYTES);
        raw   = $urandom_range(lim, 1);
        body  = int'(size);
      end
    endcase
    send_frame(8'($urandom), flags, 8'($urandom), 8'($urandom), $urandom, size, raw,
               body);
    // block is silent from here on
    repeat (30) send_byte(8'($urandom));
  endtask

  initial begin
    int ph;
    int target;
    int frames;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_byte   = '0;
    cfg_valid = 1'b0;
    cfg_index = lpfd_pkg::REG_MAX_FRAME;
    cfg_data  = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // directed frames at reset settings, then after register writes
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 32'd0, 32'h0, 0);
    send_frame(8'hFF, 8'hFE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'd1, 32'h0, 1);
    send_frame(8'h5A, 8'h03, 8'hA5, 8'h3C, 32'h8000_0001, 32'd6, 32'h0, 6);
    send_frame(8'h01, 8'h01, 8'h02, 8'h03, 32'h1234_5678, 32'd5,
               {5'd0, lpfd_pkg::MAX_FRAME_RST}, 5);
    wait_idle(6);
    write_reg(lpfd_pkg::REG_MAX_FRAME, 27'd8);
    write_reg(lpfd_pkg::REG_DICT_PRESENT, 27'd1);
    send_frame(8'h10, 8'h00, 8'h20, 8'h30, 32'h0000_00FF, 32'd8, 32'h0, 8);
    send_frame(8'h11, 8'h03, 8'h21, 8'h31, 32'hFF00_0000, 32'd8, 32'd8, 8);
    wait_idle(6);
    write_reg(lpfd_pkg::REG_MAX_FRAME, '0);
    write_reg(lpfd_pkg::REG_COMP_MASK, 27'hFF);
    send_frame(8'h77, 8'h00, 8'h88, 8'h99, 32'hDEAD_BEEF, 32'd0, 32'h0, 0);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 30; recv_idle = 55; end
        1: begin send_idle = 55; recv_idle = 30; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      target = bytes_sent + 600;
      while (bytes_sent < target) begin
        wait_idle(6);
        random_setup();
        frames = 0;
        while (frames < 10 && bytes_sent < target) begin
          random_frame();
          frames++;
        end
      end
    end

    wait_idle(6);
    error_frame();

    wait_idle(10);
    if (sb.errors == 0 && sb.expected_items.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (sb.expected_items.size() != 0)
        $display("%0t: %0d expected results never arrived", $time,
                 sb.expected_items.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
